// ===== design/fuzzy_gain_pd_steering_top_defines.svh =====
// Assertion macros shared by the fuzzy gain PD steering RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef FUZZY_GAIN_PD_STEERING_TOP_DEFINES_SVH
`define FUZZY_GAIN_PD_STEERING_TOP_DEFINES_SVH
`ifndef SYNTH
// Property holds on every clock edge outside reset
`define FGPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies the consequent in the next
`define FGPD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FGPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define FGPD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== design/fgpd_pkg.sv =====
// Package for the fuzzy gain PD steering block: widths, codes, rule table,
// register defaults and the structs passed between pipeline sections. No dependencies.
package fgpd_pkg;

    localparam int NUM_LEVELS = 5;
    localparam int ERR_W      = 16;
    localparam int BRK_W      = 15;
    localparam int KP_W       = 16;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int SUM_W      = BRK_W + KP_W;     // num * gain, below den * 2^16
    localparam int DPROD_W    = 33;               // d_gain * (e - prev)
    localparam int KPROD_W    = 32;               // kp * e
    localparam int ACC_W      = 34;
    localparam int MAG_W      = 17;               // |acc| >> 16
    localparam int RECIP_W    = 18;
    localparam int PROD_W     = MAG_W + RECIP_W;
    localparam int RECIP_SHIFT = 21;
    localparam int QUO10_W    = PROD_W - RECIP_SHIFT;
    // ceil(2^21 / 10): exact floor(x / 10) for any x below 2^17
    localparam logic [RECIP_W-1:0] RECIP10 = 18'd209716;

    // Divider: quotient bits resolved per stage
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = KP_W / DIV_STEPS;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_INNER_BREAK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_OUTER_BREAK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_INNER_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_OUTER_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_PWM      = 3'd5;

    localparam logic [BRK_W-1:0]        RST_ERR_INNER_BREAK = 15'd4096;
    localparam logic [BRK_W-1:0]        RST_ERR_OUTER_BREAK = 15'd6400;
    localparam logic [KP_W-1:0]         RST_KP_INNER_LEVEL  = 16'd1536;
    localparam logic [KP_W-1:0]         RST_KP_OUTER_LEVEL  = 16'd2765;
    localparam logic [KP_W-1:0]         RST_D_GAIN          = 16'd17920;
    localparam logic signed [ERR_W-1:0] RST_CENTER_PWM      = 16'sd0;

    // Gain levels
    typedef logic [2:0] level_t;
    localparam level_t LVL_NEG_OUTER = 3'd0;
    localparam level_t LVL_NEG_INNER = 3'd1;
    localparam level_t LVL_ZERO      = 3'd2;
    localparam level_t LVL_POS_INNER = 3'd3;
    localparam level_t LVL_POS_OUTER = 3'd4;
    localparam level_t LVL_NONE      = 3'd5;

    // Segment of the error axis; also indexes the rule column
    typedef logic [2:0] seg_t;
    localparam seg_t SEG_NEG_OUTER = 3'd0;   // below -inner
    localparam seg_t SEG_NEG_INNER = 3'd1;   // -inner .. 0
    localparam seg_t SEG_POS_INNER = 3'd2;   // 0 .. inner
    localparam seg_t SEG_POS_OUTER = 3'd3;   // inner .. outer
    localparam seg_t SEG_BEYOND    = 3'd4;   // at or above outer

    localparam level_t RULE_COL [NUM_LEVELS+1] = '{LVL_POS_OUTER, LVL_POS_INNER, LVL_ZERO,
                                                    LVL_NEG_INNER, LVL_NEG_OUTER, LVL_NONE};

    typedef struct packed {
        logic [BRK_W-1:0]        err_inner_break;
        logic [BRK_W-1:0]        err_outer_break;
        logic [KP_W-1:0]         kp_inner_level;
        logic [KP_W-1:0]         kp_outer_level;
        logic [KP_W-1:0]         d_gain;
        logic signed [ERR_W-1:0] center_pwm;
    } cfg_t;

    // Segment section -> divider
    typedef struct packed {
        logic [SUM_W-1:0]          sum;
        logic [BRK_W-1:0]          den;
        logic signed [ERR_W-1:0]   e;
        logic signed [DPROD_W-1:0] dprod;
    } quot_t;

    // Divider -> PD output section
    typedef struct packed {
        logic [KP_W-1:0]           kp;
        logic signed [ERR_W-1:0]   e;
        logic signed [DPROD_W-1:0] dprod;
    } gain_t;

    // Magnitude of a level's gain; the two levels of one segment share a sign
    function automatic logic [KP_W-1:0] level_gain(level_t lvl, logic [KP_W-1:0] ki,
                                                   logic [KP_W-1:0] ko);
        logic [KP_W-1:0] g;
        case (lvl)
            LVL_NEG_OUTER, LVL_POS_OUTER: g = ko;
            LVL_NEG_INNER, LVL_POS_INNER: g = ki;
            default:                      g = '0;
        endcase
        return g;
    endfunction

endpackage

// ===== design/fgpd_if.sv =====
// Valid/ready channel interfaces for the steering block: error beats in,
// drive beats out. No dependencies.
interface fgpd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] error_now;
    logic signed [15:0] error_prev;

    modport source (output valid, output error_now, output error_prev, input ready);
    modport sink   (input valid, input error_now, input error_prev, output ready);
endinterface

interface fgpd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] steer_pwm;
    logic [15:0]        kp_used;

    modport source (output valid, output steer_pwm, output kp_used, input ready);
    modport sink   (input valid, input steer_pwm, input kp_used, output ready);
endinterface

// ===== design/fgpd_seg.sv =====
// Fuzzy segment section: finds the error segment, weights the two level gains
// and forms the derivative product. Depends on fgpd_pkg and the defines header.
`include "fuzzy_gain_pd_steering_top_defines.svh"

module fgpd_seg
    import fgpd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [ERR_W-1:0] error_now,
    input  logic signed [ERR_W-1:0] error_prev,
    output logic                    out_valid,
    input  logic                    out_ready,
    output quot_t                   out_data
);

    typedef struct packed {
        logic [BRK_W-1:0]         num;    // distance to upper breakpoint
        logic [BRK_W-1:0]         t;      // distance from lower breakpoint
        logic [BRK_W-1:0]         den;
        logic [KP_W-1:0]          ga;
        logic [KP_W-1:0]          gb;
        logic signed [ERR_W-1:0]  e;
        logic signed [DIFF_W-1:0] diff;
    } seg_a_t;

    typedef struct packed {
        logic [SUM_W-1:0]         pa;
        logic [SUM_W-1:0]         pb;
        logic [BRK_W-1:0]         den;
        logic signed [ERR_W-1:0]  e;
        logic signed [DIFF_W-1:0] diff;
    } seg_b_t;

    logic [2:0] v_reg;
    logic [3:0] rdy;

    seg_a_t a_next, a_reg;
    seg_b_t b_next, b_reg;
    quot_t  c_next, c_reg;

    logic signed [DIFF_W-1:0] e_x, pos_in, pos_out, neg_in, neg_out, lo, hi, num_w, t_w, den_w;
    logic lt0, lt1, lt2, lt3, lt4, beyond;
    seg_t seg;

    logic [SUM_W:0]           sum_full;
    logic signed [DIFF_W-1:0] dg_s;
    logic signed [2*DIFF_W-1:0] dprod_full;

    // Stall chain: a stage loads when it is empty or the next one moves
    assign rdy[3]    = out_ready;
    assign rdy[2]    = !v_reg[2] || rdy[3];
    assign rdy[1]    = !v_reg[1] || rdy[2];
    assign rdy[0]    = !v_reg[0] || rdy[1];
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[2];
    assign out_data  = c_reg;

    // Stage A: breakpoint compares and segment selection
    always_comb
    begin
        e_x     = {error_now[ERR_W-1], error_now};
        pos_in  = {2'b00, cfg.err_inner_break};
        pos_out = {2'b00, cfg.err_outer_break};
        neg_in  = -pos_in;
        neg_out = -pos_out;
        lt0 = e_x < neg_out;
        lt1 = e_x < neg_in;
        lt2 = e_x[DIFF_W-1];
        lt3 = e_x < pos_in;
        lt4 = e_x < pos_out;

        if (lt0 || lt1)
            seg = SEG_NEG_OUTER;
        else if (lt2)
            seg = SEG_NEG_INNER;
        else if (lt3)
            seg = SEG_POS_INNER;
        else if (lt4)
            seg = SEG_POS_OUTER;
        else
            seg = SEG_BEYOND;

        // Below -outer, or past every breakpoint in test order
        beyond = lt0 || (seg == SEG_BEYOND);

        case (seg)
            SEG_NEG_OUTER: begin lo = neg_out; hi = neg_in;  end
            SEG_NEG_INNER: begin lo = neg_in;  hi = '0;      end
            SEG_POS_INNER: begin lo = '0;      hi = pos_in;  end
            SEG_POS_OUTER: begin lo = pos_in;  hi = pos_out; end
            default:       begin lo = '0;      hi = '0;      end
        endcase

        // Differences wrap only outside the selected segment
        num_w = hi - e_x;
        t_w   = e_x - lo;
        den_w = hi - lo;

        // Outside the outer breakpoints one level carries full weight
        if (beyond)
        begin
            a_next.num = BRK_W'(1);
            a_next.t   = '0;
            a_next.den = BRK_W'(1);
        end
        else
        begin
            a_next.num = num_w[BRK_W-1:0];
            a_next.t   = t_w[BRK_W-1:0];
            a_next.den = den_w[BRK_W-1:0];
        end
        a_next.ga   = level_gain(RULE_COL[seg], cfg.kp_inner_level, cfg.kp_outer_level);
        a_next.gb   = level_gain(RULE_COL[seg + 3'd1], cfg.kp_inner_level,
                                 cfg.kp_outer_level);
        a_next.e    = error_now;
        a_next.diff = {error_now[ERR_W-1], error_now} - {error_prev[ERR_W-1], error_prev};
    end

    // Stage B: membership products
    always_comb
    begin
        b_next.pa   = SUM_W'(a_reg.num) * SUM_W'(a_reg.ga);
        b_next.pb   = SUM_W'(a_reg.t) * SUM_W'(a_reg.gb);
        b_next.den  = a_reg.den;
        b_next.e    = a_reg.e;
        b_next.diff = a_reg.diff;
    end

    // Stage C: weighted sum and derivative product side by side
    always_comb
    begin
        sum_full   = {1'b0, b_reg.pa} + {1'b0, b_reg.pb};
        dg_s       = $signed({1'b0, cfg.d_gain});
        dprod_full = dg_s * $signed(b_reg.diff);
        c_next.sum   = sum_full[SUM_W-1:0];
        c_next.den   = b_reg.den;
        c_next.e     = b_reg.e;
        c_next.dprod = dprod_full[DPROD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            if (rdy[1])
                v_reg[1] <= v_reg[0];
            if (rdy[2])
                v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            a_reg <= a_next;
        if (rdy[1])
            b_reg <= b_next;
        if (rdy[2])
            c_reg <= c_next;
    end

    // Memberships of a loaded segment always add up to its width
    `FGPD_ASSERT(a_seg_weights, clk, rst_n, !v_reg[0] || ((16'(a_reg.num) + 16'(a_reg.t)) == 16'(a_reg.den) && a_reg.den != '0), "segment weights do not sum to width")

endmodule

// ===== design/fgpd_div.sv =====
// Pipelined restoring divider for the fuzzy gain: four quotient bits per
// stage, side data carried along. Depends on fgpd_pkg and the defines header.
`include "fuzzy_gain_pd_steering_top_defines.svh"

module fgpd_div
    import fgpd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  quot_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output gain_t out_data
);

    typedef struct packed {
        logic [BRK_W-1:0]          rem;
        logic [KP_W-1:0]           low;    // dividend bits still to bring down
        logic [KP_W-1:0]           q;
        logic [BRK_W-1:0]          den;
        logic signed [ERR_W-1:0]   e;
        logic signed [DPROD_W-1:0] dprod;
    } div_st_t;

    // One stage worth of restoring steps
    function automatic div_st_t div_step(div_st_t st);
        div_st_t          r;
        logic [BRK_W:0]   trial;
        r = st;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial = {r.rem, r.low[KP_W-1]};
            r.low = {r.low[KP_W-2:0], 1'b0};
            if (trial >= {1'b0, r.den})
            begin
                r.rem = BRK_W'(trial - {1'b0, r.den});
                r.q   = {r.q[KP_W-2:0], 1'b1};
            end
            else
            begin
                r.rem = trial[BRK_W-1:0];
                r.q   = {r.q[KP_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    div_st_t                 init;
    div_st_t                 st_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0]   v_reg;
    logic [DIV_STAGES:0]     rdy;

    // The quotient fits 16 bits, so the top dividend bits start as remainder
    always_comb
    begin
        init.rem   = in_data.sum[SUM_W-1:KP_W];
        init.low   = in_data.sum[KP_W-1:0];
        init.q     = '0;
        init.den   = in_data.den;
        init.e     = in_data.e;
        init.dprod = in_data.dprod;
    end

    assign rdy[DIV_STAGES] = out_ready;
    assign in_ready        = rdy[0];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        div_st_t src;
        logic    src_v;
        div_st_t st_next;

        if (s == 0)
        begin : g_first
            assign src   = init;
            assign src_v = in_valid;
        end
        else
        begin : g_rest
            assign src   = st_reg[s-1];
            assign src_v = v_reg[s-1];
        end

        assign rdy[s]  = !v_reg[s] || rdy[s+1];
        assign st_next = div_step(src);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (rdy[s])
                v_reg[s] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s])
                st_reg[s] <= st_next;
        end
    end

    assign out_valid      = v_reg[DIV_STAGES-1];
    assign out_data.kp    = st_reg[DIV_STAGES-1].q;
    assign out_data.e     = st_reg[DIV_STAGES-1].e;
    assign out_data.dprod = st_reg[DIV_STAGES-1].dprod;

    `FGPD_ASSERT(a_den_nonzero, clk, rst_n, !in_valid || (in_data.den != '0), "zero divisor entering divider")
    `FGPD_ASSERT(a_quot_fits, clk, rst_n, !(in_valid && in_ready) || (in_data.sum[SUM_W-1:KP_W] < in_data.den), "quotient would exceed 16 bits")
    `FGPD_ASSERT(a_rem_below_den, clk, rst_n, !v_reg[DIV_STAGES-1] || (st_reg[DIV_STAGES-1].rem < st_reg[DIV_STAGES-1].den), "final remainder not below divisor")

endmodule

// ===== design/fgpd_pd_out.sv =====
// PD output section: kp*e product, PD sum, scaling by 1/(2^16 * 10) with
// truncation toward zero, center offset and int16 saturation. Depends on fgpd_pkg.
module fgpd_pd_out
    import fgpd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [ERR_W-1:0] center_pwm,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  gain_t                   in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [ERR_W-1:0] steer_pwm,
    output logic [KP_W-1:0]         kp_used
);

    typedef struct packed {
        logic signed [KPROD_W-1:0] kprod;
        logic signed [DPROD_W-1:0] dprod;
        logic [KP_W-1:0]           kp;
    } pd_a_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic [KP_W-1:0]         kp;
    } pd_b_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic              neg;
        logic [KP_W-1:0]   kp;
    } pd_c_t;

    localparam logic signed [DIFF_W-1:0] PWM_MAX = 17'sd32767;
    localparam logic signed [DIFF_W-1:0] PWM_MIN = -17'sd32768;

    logic [3:0] v_reg;
    logic [4:0] rdy;

    pd_a_t a_next, a_reg;
    pd_b_t b_next, b_reg;
    pd_c_t c_next, c_reg;

    logic signed [ERR_W-1:0] steer_next, steer_reg;
    logic [KP_W-1:0]         kp_next, kp_reg;

    logic signed [KP_W:0]      kp_s;
    logic signed [KPROD_W:0]   kprod_full;
    logic [ACC_W-1:0]          mag;
    logic [MAG_W-1:0]          scaled;
    logic [QUO10_W-1:0]        q10;
    logic signed [DIFF_W-1:0]  q_s, drive;

    assign rdy[4]    = out_ready;
    assign rdy[3]    = !v_reg[3] || rdy[4];
    assign rdy[2]    = !v_reg[2] || rdy[3];
    assign rdy[1]    = !v_reg[1] || rdy[2];
    assign rdy[0]    = !v_reg[0] || rdy[1];
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[3];
    assign steer_pwm = steer_reg;
    assign kp_used   = kp_reg;

    // Stage 1: proportional product
    always_comb
    begin
        kp_s          = $signed({1'b0, in_data.kp});
        kprod_full    = kp_s * in_data.e;
        a_next.kprod  = kprod_full[KPROD_W-1:0];
        a_next.dprod  = in_data.dprod;
        a_next.kp     = in_data.kp;
    end

    // Stage 2: PD sum in Q16.16
    always_comb
    begin
        b_next.acc = {{(ACC_W-KPROD_W){a_reg.kprod[KPROD_W-1]}}, a_reg.kprod}
                   + {{(ACC_W-DPROD_W){a_reg.dprod[DPROD_W-1]}}, a_reg.dprod};
        b_next.kp  = a_reg.kp;
    end

    // Stage 3: magnitude, drop fraction, multiply by reciprocal of ten
    always_comb
    begin
        mag         = b_reg.acc[ACC_W-1] ? ACC_W'(-b_reg.acc) : b_reg.acc;
        scaled      = mag[KP_W+MAG_W-1:KP_W];
        c_next.prod = PROD_W'(scaled) * PROD_W'(RECIP10);
        c_next.neg  = b_reg.acc[ACC_W-1];
        c_next.kp   = b_reg.kp;
    end

    // Stage 4: restore sign, add center, saturate
    always_comb
    begin
        q10   = c_reg.prod[PROD_W-1:RECIP_SHIFT];
        q_s   = c_reg.neg ? -$signed(DIFF_W'(q10)) : $signed(DIFF_W'(q10));
        drive = {center_pwm[ERR_W-1], center_pwm} + q_s;
        if (drive > PWM_MAX)
            steer_next = PWM_MAX[ERR_W-1:0];
        else if (drive < PWM_MIN)
            steer_next = PWM_MIN[ERR_W-1:0];
        else
            steer_next = drive[ERR_W-1:0];
        kp_next = c_reg.kp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            if (rdy[1])
                v_reg[1] <= v_reg[0];
            if (rdy[2])
                v_reg[2] <= v_reg[1];
            if (rdy[3])
                v_reg[3] <= v_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            a_reg <= a_next;
        if (rdy[1])
            b_reg <= b_next;
        if (rdy[2])
            c_reg <= c_next;
        if (rdy[3])
        begin
            steer_reg <= steer_next;
            kp_reg    <= kp_next;
        end
    end

endmodule

// ===== design/fuzzy_gain_pd_steering_top.sv =====
// Fuzzy gain-scheduled PD steering controller, top level: configuration
// registers and the segment, divider and PD output sections.
// Depends on fgpd_pkg, fgpd_if, fgpd_seg, fgpd_div, fgpd_pd_out and the defines header.
//
//   channel  | dir | fields                              | accepted when
//   ---------+-----+-------------------------------------+----------------------
//   sample   | in  | error_now, error_prev (s16 Q8.8)    | valid && ready
//   result   | out | steer_pwm (s16), kp_used (u16 Q8.8) | valid && ready
//   cfg      | in  | cfg_index, cfg_data                 | cfg_we
//
// One beat per cycle sustained while the output is not stalled; 3 segment stages, 4 divider
// stages (the 16-bit gain quotient, 4 bits per stage), 4 PD output stages.
// Reset clears the pipeline valid bits and loads the register defaults.
// Each stage advances when empty or when the next one moves, so a stalled
// output still lets new beats fill the bubbles behind it.
`include "fuzzy_gain_pd_steering_top_defines.svh"

module fuzzy_gain_pd_steering_top
    import fgpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    fgpd_in_if.sink               sample,
    fgpd_out_if.source            result
);

    cfg_t  cfg_reg, cfg_next;

    logic  seg_valid, seg_ready;
    quot_t seg_data;
    logic  div_valid, div_ready;
    gain_t div_data;

    logic [KP_W-1:0] kp_bound;

    // Configuration writes; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ERR_INNER_BREAK: cfg_next.err_inner_break = cfg_data[BRK_W-1:0];
                CFG_ERR_OUTER_BREAK: cfg_next.err_outer_break = cfg_data[BRK_W-1:0];
                CFG_KP_INNER_LEVEL:  cfg_next.kp_inner_level  = cfg_data;
                CFG_KP_OUTER_LEVEL:  cfg_next.kp_outer_level  = cfg_data;
                CFG_D_GAIN:          cfg_next.d_gain          = cfg_data;
                CFG_CENTER_PWM:      cfg_next.center_pwm      = $signed(cfg_data);
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.err_inner_break <= RST_ERR_INNER_BREAK;
            cfg_reg.err_outer_break <= RST_ERR_OUTER_BREAK;
            cfg_reg.kp_inner_level  <= RST_KP_INNER_LEVEL;
            cfg_reg.kp_outer_level  <= RST_KP_OUTER_LEVEL;
            cfg_reg.d_gain          <= RST_D_GAIN;
            cfg_reg.center_pwm      <= RST_CENTER_PWM;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Segment, memberships, weighted gain sum
    fgpd_seg u_seg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (sample.valid),
        .in_ready   (sample.ready),
        .error_now  (sample.error_now),
        .error_prev (sample.error_prev),
        .out_valid  (seg_valid),
        .out_ready  (seg_ready),
        .out_data   (seg_data)
    );

    // Gain quotient
    fgpd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .in_data   (seg_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    // PD drive and output register
    fgpd_pd_out u_pd (
        .clk        (clk),
        .rst_n      (rst_n),
        .center_pwm (cfg_reg.center_pwm),
        .in_valid   (div_valid),
        .in_ready   (div_ready),
        .in_data    (div_data),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .steer_pwm  (result.steer_pwm),
        .kp_used    (result.kp_used)
    );

    // The gain is a convex mix of the two level gains
    assign kp_bound = (cfg_reg.kp_inner_level > cfg_reg.kp_outer_level) ?
                      cfg_reg.kp_inner_level : cfg_reg.kp_outer_level;

    `FGPD_ASSERT_NEXT(a_kp_bounded, clk, rst_n, 1'b1, !result.valid || (result.kp_used <= kp_bound), "gain above both level gains")

endmodule
